### src/fpd_pkg.sv
package fpd_pkg;

    localparam int WINDOW_LENGTH_DEF = 16;
    localparam int MAX_TONES_DEF     = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam int ENERGY_W  = 32;
    localparam int TONE_W    = 4;
    localparam int COUNT_W   = 5;
    localparam int PATTERN_W = 64;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b1;

    localparam logic [PATTERN_W-1:0] PATTERN_RESET   = '0;
    localparam logic [COUNT_W-1:0]   THRESHOLD_RESET = 5'd2;

    // One hard symbol decision handed from the front end to the back end.
    typedef struct packed {
        logic [TONE_W-1:0] tone;
        logic              frame_end;
    } decision_t;

    typedef struct packed {
        logic      valid;
        decision_t decision;
    } queue_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### src/fpd_if.sv
interface fpd_energy_if;
    logic                          valid;
    logic                          ready;
    logic [fpd_pkg::ENERGY_W-1:0]  tone_energy;
    logic                          symbol_end;
    logic                          frame_end;

    modport source (output valid, output tone_energy, output symbol_end,
                    output frame_end, input ready);
    modport sink   (input valid, input tone_energy, input symbol_end,
                    input frame_end, output ready);
endinterface

interface fpd_result_if;
    logic                         valid;
    logic                         ready;
    logic                         detected;
    logic [fpd_pkg::COUNT_W-1:0]  best_matches;

    modport source (output valid, output detected, output best_matches, input ready);
    modport sink   (input valid, input detected, input best_matches, output ready);
endinterface

interface fpd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fpd_pkg::CFG_IDX_W-1:0]  index;
    logic [fpd_pkg::PATTERN_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/fpd_front.sv
// Tracks the loudest tone of the current symbol and emits one decision per symbol.
module fpd_front #(
    parameter int MAX_TONES = fpd_pkg::MAX_TONES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [fpd_pkg::ENERGY_W-1:0]  tone_energy,
    input  logic                          symbol_end,
    input  logic                          frame_end,
    input  fpd_pkg::queue_status_t        q_status,
    output logic                          in_ready,
    output fpd_pkg::queue_push_t          push
);

    localparam int POS_W = $clog2(MAX_TONES + 1);

    logic [fpd_pkg::ENERGY_W-1:0] peak_energy_reg, peak_energy_next;
    logic [fpd_pkg::TONE_W-1:0]   peak_tone_reg, peak_tone_next;
    logic [POS_W-1:0]             pos_reg, pos_next;

    logic                         accept;
    logic                         take;
    logic                         update;
    logic                         ends;
    logic [fpd_pkg::ENERGY_W-1:0] cur_energy;
    logic [fpd_pkg::TONE_W-1:0]   cur_tone;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign ends     = symbol_end || frame_end;

    always_comb
    begin
        take       = (pos_reg < POS_W'(MAX_TONES));
        update     = take && ((pos_reg == '0) || (tone_energy > peak_energy_reg));
        cur_energy = update ? tone_energy : peak_energy_reg;
        cur_tone   = update ? fpd_pkg::TONE_W'(pos_reg) : peak_tone_reg;
    end

    always_comb
    begin
        peak_energy_next = peak_energy_reg;
        peak_tone_next   = peak_tone_reg;
        pos_next         = pos_reg;
        if (accept)
        begin
            if (ends)
            begin
                peak_energy_next = '0;
                peak_tone_next   = '0;
                pos_next         = '0;
            end
            else
            begin
                peak_energy_next = cur_energy;
                peak_tone_next   = cur_tone;
                pos_next         = take ? pos_reg + POS_W'(1) : pos_reg;
            end
        end
    end

    always_comb
    begin
        push.valid              = accept && ends;
        push.decision.tone      = cur_tone;
        push.decision.frame_end = frame_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_energy_reg <= '0;
            peak_tone_reg   <= '0;
            pos_reg         <= '0;
        end
        else
        begin
            peak_energy_reg <= peak_energy_next;
            peak_tone_reg   <= peak_tone_next;
            pos_reg         <= pos_next;
        end
    end

endmodule

### src/fpd_queue.sv
// Small decision queue between the front end and the back end.
module fpd_queue #(
    parameter int DEPTH = fpd_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fpd_pkg::queue_push_t    push,
    input  logic                    pop,
    output fpd_pkg::queue_status_t  status,
    output fpd_pkg::decision_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fpd_pkg::decision_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push.valid ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.decision;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/fpd_back.sv
// Shifts decisions into the window, scores it against the preamble and reports per frame.
module fpd_back #(
    parameter int WINDOW_LENGTH = fpd_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fpd_pkg::queue_status_t         q_status,
    input  fpd_pkg::decision_t             head,
    input  logic [fpd_pkg::PATTERN_W-1:0]  pattern,
    input  logic [fpd_pkg::COUNT_W-1:0]    threshold,
    input  logic                           out_ready,
    output logic                           pop,
    output logic                           out_valid,
    output logic                           detected,
    output logic [fpd_pkg::COUNT_W-1:0]    best_matches
);

    localparam int SEEN_W = $clog2(WINDOW_LENGTH + 1);
    localparam int TW     = fpd_pkg::TONE_W;
    localparam int CW     = fpd_pkg::COUNT_W;

    logic [TW-1:0]     window_reg [WINDOW_LENGTH];
    logic [TW-1:0]     window_next [WINDOW_LENGTH];
    logic [TW-1:0]     shifted [WINDOW_LENGTH];
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [CW-1:0]     best_reg, best_next;
    logic              out_valid_reg, out_valid_next;
    logic              detected_reg, detected_next;
    logic [CW-1:0]     result_reg, result_next;

    logic                     slot_free;
    logic [SEEN_W-1:0]        seen_inc;
    logic [WINDOW_LENGTH-1:0] match_vec;
    logic [CW-1:0]            match_total;
    logic [CW-1:0]            best_upd;

    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = !q_status.empty && (!head.frame_end || slot_free);

    always_comb
    begin
        for (int i = 0; i < WINDOW_LENGTH - 1; i++)
        begin
            shifted[i] = window_reg[i + 1];
        end
        shifted[WINDOW_LENGTH - 1] = head.tone;
        for (int i = 0; i < WINDOW_LENGTH; i++)
        begin
            match_vec[i] = (shifted[i] == pattern[TW * i +: TW]);
        end
        match_total = CW'($countones(match_vec));
        seen_inc = (seen_reg < SEEN_W'(WINDOW_LENGTH)) ? seen_reg + SEEN_W'(1) : seen_reg;
        best_upd = ((seen_inc == SEEN_W'(WINDOW_LENGTH)) && (match_total > best_reg))
                   ? match_total : best_reg;
    end

    always_comb
    begin
        window_next = window_reg;
        seen_next   = seen_reg;
        best_next   = best_reg;
        if (pop)
        begin
            if (head.frame_end)
            begin
                for (int i = 0; i < WINDOW_LENGTH; i++)
                begin
                    window_next[i] = '0;
                end
                seen_next = '0;
                best_next = '0;
            end
            else
            begin
                window_next = shifted;
                seen_next   = seen_inc;
                best_next   = best_upd;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        detected_next  = detected_reg;
        result_next    = result_reg;
        if (pop && head.frame_end)
        begin
            out_valid_next = 1'b1;
            detected_next  = (best_upd >= threshold);
            result_next    = best_upd;
        end
    end

    assign out_valid    = out_valid_reg;
    assign detected     = detected_reg;
    assign best_matches = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LENGTH; i++)
            begin
                window_reg[i] <= '0;
            end
            seen_reg      <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            window_reg    <= window_next;
            seen_reg      <= seen_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        detected_reg <= detected_next;
        result_reg   <= result_next;
    end

endmodule

### src/fsk_preamble_detector_core.sv
// Throughput: one tone energy transaction per cycle while the decision queue is not full,
// sustained; set by the front end's peak compare and the back end's window score.
// A frame result goes from the transaction that ends the frame through the decision
// queue to the result register; the queue holds it while the previous result waits.
// Reset: rst_n is asynchronous and active low; it clears all frame state and restores
// the preamble pattern to zero and the match threshold to two. No clearing pass is needed.
module fsk_preamble_detector_core #(
    parameter int WINDOW_LENGTH = fpd_pkg::WINDOW_LENGTH_DEF,
    parameter int MAX_TONES     = fpd_pkg::MAX_TONES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    fpd_energy_if.sink    energy_ch,
    fpd_result_if.source  result_ch,
    fpd_cfg_if.sink       cfg_ch
);

    // Configuration registers. The user must write them only while the block is idle;
    // not enforced here. cfg_ch is always ready; the back end reads them directly.
    logic [fpd_pkg::PATTERN_W-1:0] pattern_reg, pattern_next;
    logic [fpd_pkg::COUNT_W-1:0]   threshold_reg, threshold_next;

    fpd_pkg::queue_push_t   q_push;
    fpd_pkg::queue_status_t q_status;
    fpd_pkg::decision_t     q_head;
    logic                   q_pop;

    assign cfg_ch.ready = 1'b1;

    always_comb
    begin
        pattern_next   = pattern_reg;
        threshold_next = threshold_reg;
        if (cfg_ch.valid && cfg_ch.ready)
        begin
            unique case (cfg_ch.index)
                fpd_pkg::CFG_PATTERN:
                begin
                    pattern_next = cfg_ch.data;
                end
                fpd_pkg::CFG_THRESHOLD:
                begin
                    threshold_next = cfg_ch.data[fpd_pkg::COUNT_W-1:0];
                end
                default:
                begin
                    pattern_next = pattern_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg   <= fpd_pkg::PATTERN_RESET;
            threshold_reg <= fpd_pkg::THRESHOLD_RESET;
        end
        else
        begin
            pattern_reg   <= pattern_next;
            threshold_reg <= threshold_next;
        end
    end

    // The front end picks the loudest tone of each symbol, the lower index winning a
    // tie, and pushes one decision when the symbol or the frame ends. Energies past
    // the last tone bin of a symbol are ignored, but their end flags still count.
    fpd_front #(
        .MAX_TONES (MAX_TONES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (energy_ch.valid),
        .tone_energy (energy_ch.tone_energy),
        .symbol_end  (energy_ch.symbol_end),
        .frame_end   (energy_ch.frame_end),
        .q_status    (q_status),
        .in_ready    (energy_ch.ready),
        .push        (q_push)
    );

    // The queue lets the front end keep taking energies while a finished result waits
    // downstream until full; with the back end draining every cycle it never fills.
    fpd_queue #(
        .DEPTH (fpd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .pop    (q_pop),
        .status (q_status),
        .head   (q_head)
    );

    // The back end shifts each decision into the window, scores a full window
    // against the preamble, keeps the best score of the frame and, on the frame's
    // last decision, loads the result register and clears its frame state.
    fpd_back #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head         (q_head),
        .pattern      (pattern_reg),
        .threshold    (threshold_reg),
        .out_ready    (result_ch.ready),
        .pop          (q_pop),
        .out_valid    (result_ch.valid),
        .detected     (result_ch.detected),
        .best_matches (result_ch.best_matches)
    );

`ifndef NO_ASSERTIONS
    // The front end must never push into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push.valid && q_status.full))
        else $error("decision pushed into a full queue");

    // A new result only appears after the back end has taken a frame-ending decision.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_ch.valid) |-> $past(q_pop && q_head.frame_end))
        else $error("result appeared without a frame-ending decision");

    // The reported score can never exceed the window length.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> (result_ch.best_matches <= fpd_pkg::COUNT_W'(WINDOW_LENGTH)))
        else $error("best match count exceeds the window length");

    // The detection flag agrees with the score and the threshold.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid |-> (result_ch.detected == (result_ch.best_matches >= threshold_reg)))
        else $error("detection flag disagrees with the threshold");
`endif

endmodule
